// ===== rtl/srgb_gamma_brightness_pixel_top_assert.svh =====
// Assertion macros for the sRGB gamma / brightness block.
// The enclosing module provides clk and rst.
`ifndef SRGB_GAMMA_BRIGHTNESS_PIXEL_TOP_ASSERT_SVH
`define SRGB_GAMMA_BRIGHTNESS_PIXEL_TOP_ASSERT_SVH
`ifndef SYNTH
`define SGB_CHK_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sgb check failed");
`define SGB_CHK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sgb check failed");
`else
`define SGB_CHK_NOW(lbl, pre, post)
`define SGB_CHK_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/sgb_pkg.sv =====
`default_nettype none
package sgb_pkg;

  localparam int LIN_FRAC  = 16;
  localparam int ENC_BITS  = 12;
  localparam int LIN_W     = LIN_FRAC + 1;
  localparam int IDX_W     = ENC_BITS + 1;
  localparam int ENC_SIZE  = (1 << ENC_BITS) + 1;
  localparam int LOG_STEPS = 16;
  localparam int EXP_STEPS = 16;
  localparam int ENC_STEPS = 8;
  localparam int POW_LAT   = LOG_STEPS + EXP_STEPS + 3;
  localparam int LANE_LAT  = 1 + POW_LAT + 2 + ENC_STEPS;
  localparam logic [15:0] IG_ONE = 16'd4096;

  typedef logic [LIN_W-1:0] lin_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [63:0] root_arr_t [17];
  typedef lin_t lin_arr_t [256];

  typedef struct packed {
    logic [15:0]        ig;
    logic signed [15:0] bo;
  } cfg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic root_arr_t build_roots();
    root_arr_t rc;
    rc[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) rc[k] = isqrt64(rc[k-1] << 32);
    return rc;
  endfunction

  localparam root_arr_t ROOT_C = build_roots();

  function automatic logic [63:0] neg_log2_f(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] e;
    logic [63:0] frac;
    y = x;
    e = 64'd0;
    frac = 64'd0;
    if (x == 64'd0) return 64'd64 << 16;
    while (y < (64'd1 << 30)) begin
      y = y << 1;
      e = e + 64'd1;
    end
    for (int i = 1; i <= 16; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac = frac | (64'd1 << (16 - i));
      end
    end
    return (e << 16) - frac;
  endfunction

  function automatic logic [63:0] exp2_neg_f(input logic [63:0] m);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] p;
    logic [63:0] sh;
    n = m >> 16;
    f = m & 64'hFFFF;
    p = 64'd1 << 32;
    if (n > 64'd40) return 64'd0;
    for (int k = 1; k <= 16; k++)
      if (f[16-k]) p = (p * ROOT_C[k] + (64'd1 << 31)) >> 32;
    sh = 64'(32 - LIN_FRAC) + n;
    return (p + (64'd1 << (sh - 64'd1))) >> sh;
  endfunction

  function automatic logic [63:0] decode_half(input logic [63:0] t);
    logic [63:0] b30;
    if (t <= 64'd20)
      return (((t * 64'd100) << LIN_FRAC) + 64'd329460) / 64'd658920;
    b30 = ((t * 64'd1000 + 64'd28050) << 30) / 64'd538050;
    return exp2_neg_f((neg_log2_f(b30) * 64'd12 + 64'd2) / 64'd5);
  endfunction

  function automatic lin_arr_t build_dec();
    lin_arr_t d;
    for (int i = 0; i < 256; i++) d[i] = lin_t'(decode_half(64'(i) * 64'd2));
    return d;
  endfunction

  function automatic lin_arr_t build_thr();
    lin_arr_t d;
    d[0] = '0;
    for (int k = 1; k < 256; k++) d[k] = lin_t'(decode_half(64'(k) * 64'd2 - 64'd1));
    return d;
  endfunction

  localparam lin_arr_t DEC_ROM = build_dec();
  localparam lin_arr_t THR_ROM = build_thr();

endpackage
`default_nettype wire

// ===== rtl/sgb_pow.sv =====
`default_nettype none
module sgb_pow (
  input  wire               clk,
  input  wire               en,
  input  wire sgb_pkg::lin_t lin,
  input  wire [15:0]        ig,
  output sgb_pkg::lin_t     lin_pow
);
  localparam int LS = sgb_pkg::LOG_STEPS;
  localparam int ES = sgb_pkg::EXP_STEPS;
  localparam int LF = sgb_pkg::LIN_FRAC;

  logic [30:0] y  [LS+1];
  logic [4:0]  e  [LS+1];
  logic [15:0] fr [LS+1];

  logic [30:0] x_w;
  logic [30:0] y_w;
  logic [4:0]  e_w;

  always_comb begin
    x_w = 31'(lin) << (30 - LF);
    e_w = '0;
    for (int i = 0; i < 31; i++) if (x_w[i]) e_w = 5'(30 - i);
    y_w = x_w << e_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y[0]  <= y_w;
      e[0]  <= e_w;
      fr[0] <= '0;
    end
  end

  for (genvar i = 1; i <= LS; i++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] sh;
    assign sq = 62'(y[i-1]) * 62'(y[i-1]);
    assign sh = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        y[i]  <= sh[31] ? sh[31:1] : sh[30:0];
        e[i]  <= e[i-1];
        fr[i] <= fr[i-1] | (sh[31] ? (16'd1 << (LS - i)) : 16'd0);
      end
    end
  end

  logic [20:0] m_w;
  logic [36:0] pr_w;
  logic [8:0]  nf [ES+1];
  logic [15:0] ff [ES+1];
  logic [32:0] pq [ES+1];

  assign m_w  = {e[LS], 16'd0} - 21'(fr[LS]);
  assign pr_w = 37'(m_w) * 37'(ig) + 37'd2048;

  always_ff @(posedge clk) begin
    if (en) begin
      nf[0] <= pr_w[36:28];
      ff[0] <= pr_w[27:12];
      pq[0] <= 33'h1_0000_0000;
    end
  end

  for (genvar j = 1; j <= ES; j++) begin : g_ex
    logic [64:0] prod;
    assign prod = 65'(pq[j-1]) * 65'(sgb_pkg::ROOT_C[j][31:0]) + (65'd1 << 31);
    always_ff @(posedge clk) begin
      if (en) begin
        pq[j] <= ff[j-1][16-j] ? prod[64:32] : pq[j-1];
        nf[j] <= nf[j-1];
        ff[j] <= ff[j-1];
      end
    end
  end

  logic [6:0]  sh_w;
  logic [63:0] sum_w;
  sgb_pkg::lin_t res_w;

  always_comb begin
    sh_w  = 7'(32 - LF) + 7'(nf[ES][5:0]);
    sum_w = 64'(pq[ES]) + (64'd1 << (sh_w - 7'd1));
    if (nf[ES] > 9'd40) res_w = '0;
    else res_w = sgb_pkg::lin_t'(sum_w >> sh_w);
  end

  always_ff @(posedge clk) begin
    if (en) lin_pow <= res_w;
  end
endmodule
`default_nettype wire

// ===== rtl/sgb_enc.sv =====
`default_nettype none
module sgb_enc (
  input  wire                clk,
  input  wire                en,
  input  wire sgb_pkg::idx_t idx,
  output logic [7:0]         code
);
  localparam int NS = sgb_pkg::ENC_STEPS;
  localparam int CW = sgb_pkg::LIN_W + sgb_pkg::ENC_BITS;

  logic [7:0]    c  [NS];
  sgb_pkg::idx_t ix [NS];

  for (genvar j = 0; j < NS; j++) begin : g_st
    logic [7:0]    cp;
    sgb_pkg::idx_t ip;
    logic [7:0]    cand;
    logic          hit;
    if (j == 0) begin : g_first
      assign cp = '0;
      assign ip = idx;
    end else begin : g_rest
      assign cp = c[j-1];
      assign ip = ix[j-1];
    end
    assign cand = cp | (8'd1 << (NS - 1 - j));
    assign hit  = (CW'(sgb_pkg::THR_ROM[cand]) << sgb_pkg::ENC_BITS)
                  <= (CW'(ip) << sgb_pkg::LIN_FRAC);
    always_ff @(posedge clk) begin
      if (en) begin
        c[j]  <= hit ? cand : cp;
        ix[j] <= ip;
      end
    end
  end

  assign code = c[NS-1];
endmodule
`default_nettype wire

// ===== rtl/sgb_lane.sv =====
`default_nettype none
module sgb_lane (
  input  wire                clk,
  input  wire                en,
  input  wire [7:0]          code_in,
  input  wire sgb_pkg::cfg_t cfg,
  output logic [7:0]         code_out
);
  localparam int PL = sgb_pkg::POW_LAT;
  localparam int CD = PL + 2 + sgb_pkg::ENC_STEPS;
  localparam int OW = sgb_pkg::LIN_FRAC + 18;
  localparam int LF = sgb_pkg::LIN_FRAC;
  localparam int EB = sgb_pkg::ENC_BITS;

  sgb_pkg::lin_t lin0;
  logic [7:0]    code0;
  always_ff @(posedge clk) begin
    if (en) begin
      lin0  <= sgb_pkg::DEC_ROM[code_in];
      code0 <= code_in;
    end
  end

  sgb_pkg::lin_t lin_pow;
  sgb_pow u_pow (
    .clk    (clk),
    .en     (en),
    .lin    (lin0),
    .ig     (cfg.ig),
    .lin_pow(lin_pow)
  );

  sgb_pkg::lin_t ld [PL];
  logic [7:0]    cd [CD];
  always_ff @(posedge clk) begin
    if (en) begin
      ld[0] <= lin0;
      for (int i = 1; i < PL; i++) ld[i] <= ld[i-1];
      cd[0] <= code0;
      for (int i = 1; i < CD; i++) cd[i] <= cd[i-1];
    end
  end

  logic signed [OW-1:0] bo_x;
  logic signed [OW-1:0] ofs;
  logic signed [OW-1:0] ssum;
  sgb_pkg::lin_t        lsel;
  sgb_pkg::lin_t        lb_w;
  sgb_pkg::lin_t        linb;

  always_comb begin
    bo_x = OW'(cfg.bo);
    ofs  = ((bo_x <<< LF) + OW'(8192)) >>> 14;
    lsel = (cfg.ig != sgb_pkg::IG_ONE && ld[PL-1] != '0) ? lin_pow : ld[PL-1];
    ssum = $signed(OW'(lsel)) + ofs;
    if (ssum < 0) lb_w = '0;
    else if (ssum > $signed(OW'(1) <<< LF)) lb_w = sgb_pkg::lin_t'(1) << LF;
    else lb_w = sgb_pkg::lin_t'(ssum);
  end

  logic [LF+EB:0] ix_w;
  sgb_pkg::idx_t  idx;
  always_comb begin
    ix_w = ((LF+EB+1)'(linb) << EB) + ((LF+EB+1)'(1) << (LF - 1));
    ix_w = ix_w >> LF;
    if (ix_w >= (LF+EB+1)'(sgb_pkg::ENC_SIZE)) ix_w = (LF+EB+1)'(sgb_pkg::ENC_SIZE - 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      linb <= lb_w;
      idx  <= sgb_pkg::idx_t'(ix_w);
    end
  end

  logic [7:0] enc_code;
  sgb_enc u_enc (
    .clk (clk),
    .en  (en),
    .idx (idx),
    .code(enc_code)
  );

  assign code_out = (cfg.ig == sgb_pkg::IG_ONE && cfg.bo == '0) ? cd[CD-1] : enc_code;
endmodule
`default_nettype wire

// ===== rtl/srgb_gamma_brightness_pixel_top.sv =====
// Channel   Handshake               Payload
// in        in_valid / in_stall     red_in green_in blue_in alpha_in last_pixel
// out       out_valid / out_stall   red_out green_out blue_out alpha_out last_out
// cfg       cfg_we                  cfg_index cfg_data
//
// One pixel per cycle while the output is not stalled.
// Latency is set by the 16-step log2 squaring chain and the 16-step exp2
// product chain in each of the three color lanes, plus the 8-step encode search.
// rst is synchronous; it clears the valid pipeline and loads the default registers.
// An output stall while out_valid is high holds the whole pipeline and the input.
`default_nettype none
module srgb_gamma_brightness_pixel_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [7:0]  red_in,
  input  wire [7:0]  green_in,
  input  wire [7:0]  blue_in,
  input  wire [7:0]  alpha_in,
  input  wire        last_pixel,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out,
  output logic       last_out,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [15:0] cfg_data
);
  localparam int LL = sgb_pkg::LANE_LAT;
  localparam logic REG_IG = 1'b0;
  localparam logic REG_BO = 1'b1;

  sgb_pkg::cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ig <= sgb_pkg::IG_ONE;
      cfg.bo <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IG:  cfg.ig <= cfg_data;
        REG_BO:  cfg.bo <= $signed(cfg_data);
        default: cfg.ig <= cfg.ig;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic [7:0] codes_in  [3];
  logic [7:0] codes_out [3];
  assign codes_in[0] = red_in;
  assign codes_in[1] = green_in;
  assign codes_in[2] = blue_in;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sgb_lane u_lane (
      .clk     (clk),
      .en      (en),
      .code_in (codes_in[g]),
      .cfg     (cfg),
      .code_out(codes_out[g])
    );
  end

  logic [LL-1:0] vp;
  logic [7:0]    ad [LL];
  logic [LL-1:0] lp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[LL-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad[0] <= alpha_in;
      for (int i = 1; i < LL; i++) ad[i] <= ad[i-1];
      lp <= {lp[LL-2:0], last_pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vp[LL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_out   <= codes_out[0];
      green_out <= codes_out[1];
      blue_out  <= codes_out[2];
      alpha_out <= ad[LL-1];
      last_out  <= lp[LL-1];
    end
  end

`include "srgb_gamma_brightness_pixel_top_assert.svh"
  `SGB_CHK_NOW(a_hold_in, out_valid && out_stall, in_stall)
  `SGB_CHK_NEXT(a_hold_pipe, out_valid && out_stall, $stable(vp))
  `SGB_CHK_NEXT(a_drain, vp[LL-1] && en, out_valid)
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       l;
  } pix_t;

  typedef struct packed {
    pix_t        px;
    logic [15:0] ig;
    logic [15:0] bo;
    logic        known;
    pix_t        res;
  } row_t;

  localparam logic CFG_GAMMA = 1'b0;
  localparam logic CFG_BRIGHT = 1'b1;
  localparam int SETTLE = 60;
  localparam int WATCH_LIMIT = 3000;
  localparam int N_ROWS = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0, alpha_in = '0;
  logic last_pixel = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red_out, green_out, blue_out, alpha_out;
  logic last_out;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  logic [63:0] sqrt_steps [17];
  logic [63:0] lin_of_code [256];
  logic [63:0] half_thr [256];
  logic [7:0] code_of_lin [4097];
  logic [15:0] cur_gamma = 16'd4096;
  logic [15:0] cur_bright = 16'd0;

  pix_t pending_px [$];
  row_t rows [N_ROWS];
  int mismatches = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit long_hold = 0;

  srgb_gamma_brightness_pixel_top i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v, r, bt;
    v = v_in;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] minus_log2(input logic [63:0] x);
    logic [63:0] y, ex, fr;
    y = x;
    ex = 0;
    fr = 0;
    if (x == 0) return 64'd64 << 16;
    while (y < (64'd1 << 30)) begin
      y = y << 1;
      ex++;
    end
    for (int i = 1; i <= 16; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        fr[16-i] = 1'b1;
      end
    end
    return (ex << 16) - fr;
  endfunction

  function automatic logic [63:0] pow2_neg(input logic [63:0] m);
    logic [63:0] n, acc, sh;
    n = m >> 16;
    acc = 64'd1 << 32;
    if (n > 40) return 0;
    for (int k = 1; k <= 16; k++)
      if (m[16-k]) acc = (acc * sqrt_steps[k] + (64'd1 << 31)) >> 32;
    sh = 16 + n;
    return (acc + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [63:0] srgb_to_lin(input logic [63:0] t);
    logic [63:0] base;
    if (t <= 20) return (((t * 100) << 16) + 329460) / 658920;
    base = ((t * 1000 + 28050) << 30) / 538050;
    return pow2_neg((minus_log2(base) * 12 + 2) / 5);
  endfunction

  function automatic void build_curves();
    int k;
    sqrt_steps[0] = 64'd1 << 31;
    for (int i = 1; i <= 16; i++) sqrt_steps[i] = int_sqrt(sqrt_steps[i-1] << 32);
    for (int i = 0; i < 256; i++) lin_of_code[i] = srgb_to_lin(i * 2);
    half_thr[0] = 0;
    for (int i = 1; i < 256; i++) half_thr[i] = srgb_to_lin(i * 2 - 1);
    k = 1;
    for (int i = 0; i < 4097; i++) begin
      while (k <= 255 && (half_thr[k] << 12) <= (64'(i) << 16)) k++;
      code_of_lin[i] = 8'(k - 1);
    end
  endfunction

  function automatic logic [7:0] adjust_code(input logic [7:0] code);
    logic [63:0] lin, m, idx;
    longint s;
    if (cur_gamma == 16'd4096 && cur_bright == 16'd0) return code;
    lin = lin_of_code[code];
    if (cur_gamma != 16'd4096 && lin > 0) begin
      m = minus_log2(lin << 14);
      lin = pow2_neg((m * cur_gamma + 2048) >> 12);
    end
    s = longint'(lin) * 16384 + longint'($signed(cur_bright)) * 65536;
    if (s < 0) s = 0;
    if (s > 65536 * 16384) s = 65536 * 16384;
    lin = (64'(s) + 8192) >> 14;
    idx = ((lin << 12) + 32768) >> 16;
    if (idx > 4096) idx = 4096;
    return code_of_lin[idx];
  endfunction

  function automatic pix_t graded_pixel(input pix_t p);
    pix_t q;
    q = p;
    q.r = adjust_code(p.r);
    q.g = adjust_code(p.g);
    q.b = adjust_code(p.b);
    return q;
  endfunction

  task automatic send_pixel(input pix_t p, input bit known, input pix_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    {red_in, green_in, blue_in, alpha_in, last_pixel} <= p;
    do @(posedge clk); while (in_stall);
    pending_px.insert(pending_px.size(), known ? res : graded_pixel(p));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grading(input logic [15:0] ig, input logic [15:0] bo);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GAMMA;
    cfg_data <= ig;
    @(posedge clk);
    cfg_index <= CFG_BRIGHT;
    cfg_data <= bo;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_gamma = ig;
    cur_bright = bo;
  endtask

  function automatic pix_t rand_pixel();
    return pix_t'({$urandom(), 1'b0}) | pix_t'($urandom_range(0, 1));
  endfunction

  always @(posedge clk) begin
    pix_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {red_out, green_out, blue_out, alpha_out, last_out};
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_px.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r%h g%h b%h a%h l%b, got r%h g%h b%h a%h l%b",
                     want.r, want.g, want.b, want.a, want.l,
                     got.r, got.g, got.b, got.a, got.l);
        end
      end
    end
  end

  always @(posedge clk) begin
    int hold_left;
    int mode;
    int tick;
    if (long_hold) begin
      long_hold = 0;
      hold_left = 200;
    end
    if (tick % 64 == 0) mode = $urandom_range(0, 2);
    tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (mode == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 9) < (mode == 1 ? 3 : 7));
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] ig, bo;
    build_curves();
    rows[0]  = '{'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 16'd4096, 16'h0000, 1'b1,
                 '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}};
    rows[1]  = '{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, 16'd4096, 16'h0000, 1'b1,
                 '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}};
    rows[2]  = '{'{8'd1, 8'd128, 8'd254, 8'd170, 1'b0}, 16'd4096, 16'h0000, 1'b1,
                 '{8'd1, 8'd128, 8'd254, 8'd170, 1'b0}};
    rows[3]  = '{'{8'd0, 8'd1, 8'd200, 8'd5, 1'b1}, 16'd4096, 16'h7FFF, 1'b1,
                 '{8'd255, 8'd255, 8'd255, 8'd5, 1'b1}};
    rows[4]  = '{'{8'd255, 8'd128, 8'd1, 8'd9, 1'b0}, 16'd4096, 16'h8000, 1'b1,
                 '{8'd0, 8'd0, 8'd0, 8'd9, 1'b0}};
    rows[5]  = '{'{8'd0, 8'd1, 8'd255, 8'd85, 1'b1}, 16'd0, 16'h0000, 1'b1,
                 '{8'd0, 8'd255, 8'd255, 8'd85, 1'b1}};
    rows[6]  = '{'{8'd0, 8'd255, 8'd255, 8'd0, 1'b0}, 16'd65535, 16'h0000, 1'b1,
                 '{8'd0, 8'd255, 8'd255, 8'd0, 1'b0}};
    rows[7]  = '{'{8'd1, 8'd100, 8'd240, 8'd33, 1'b1}, 16'd65535, 16'h0000, 1'b0, '0};
    rows[8]  = '{'{8'd10, 8'd11, 8'd12, 8'd13, 1'b0}, 16'd0, 16'h0000, 1'b0, '0};
    rows[9]  = '{'{8'd0, 8'd60, 8'd250, 8'd77, 1'b0}, 16'd4096, 16'd100, 1'b0, '0};
    rows[10] = '{'{8'd5, 8'd128, 8'd255, 8'd66, 1'b1}, 16'd4096, 16'hFF9C, 1'b0, '0};
    rows[11] = '{'{8'd3, 8'd90, 8'd230, 8'd44, 1'b0}, 16'd8192, 16'h0000, 1'b0, '0};
    rows[12] = '{'{8'd7, 8'd150, 8'd201, 8'd22, 1'b1}, 16'd2048, 16'h0000, 1'b0, '0};
    rows[13] = '{'{8'd2, 8'd64, 8'd254, 8'd11, 1'b0}, 16'd1, 16'h0000, 1'b0, '0};
    rows[14] = '{'{8'd20, 8'd120, 8'd180, 8'd99, 1'b0}, 16'd12000, 16'h2000, 1'b0, '0};
    rows[15] = '{'{8'd40, 8'd140, 8'd220, 8'd200, 1'b1}, 16'd6000, 16'hE000, 1'b0, '0};
    rows[16] = '{'{8'd4, 8'd11, 8'd255, 8'd128, 1'b0}, 16'd4096, 16'h0001, 1'b0, '0};
    rows[17] = '{'{8'd10, 8'd11, 8'd12, 8'd1, 1'b0}, 16'd4096, 16'hFFFF, 1'b0, '0};
    rows[18] = '{'{8'd255, 8'd0, 8'd128, 8'd254, 1'b1}, 16'd4095, 16'h0000, 1'b0, '0};
    rows[19] = '{'{8'd30, 8'd31, 8'd32, 8'd127, 1'b0}, 16'd4097, 16'h4000, 1'b0, '0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (rows[i].ig != cur_gamma || rows[i].bo != cur_bright) begin
        drain();
        set_grading(rows[i].ig, rows[i].bo);
      end
      send_pixel(rows[i].px, rows[i].known, rows[i].res);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin ig = 16'd65535; bo = 16'h7FFF; end
        1: begin ig = 16'd1;     bo = 16'h8000; end
        2: begin ig = 16'd4096;  bo = 16'h0000; end
        default: begin
          ig = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(2048, 12288)) : 16'($urandom);
          bo = ($urandom_range(0, 1) == 0) ? 16'($signed($urandom_range(0, 4000)) - 2000)
                                           : 16'($urandom);
        end
      endcase
      set_grading(ig, bo);
      if (ph == 4) long_hold = 1;
      repeat (50) send_pixel(rand_pixel(), 1'b0, '0);
    end

    drain();
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sgb_pkg.sv
rtl/sgb_pow.sv
rtl/sgb_enc.sv
rtl/sgb_lane.sv
rtl/srgb_gamma_brightness_pixel_top.sv
sim/tb.sv
